FILE: src/bsdc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsdc_pkg
// Types and constants for the blocked sparse delta codec.
// ----------------------------------------------------------------------------
package bsdc_pkg;

  localparam int unsigned POS_W   = 12;
  localparam int unsigned FIELD_W = 8;
  localparam int unsigned RANGE_W = 20;
  localparam int unsigned BASE_W  = 16;
  localparam int unsigned KIND_W  = 2;

  localparam int unsigned COL_SHIFT_DEF  = 4;
  localparam int unsigned BLOCK_ROWS_DEF = 256;
  localparam int unsigned ENTRY_BITS_DEF = 20;

  localparam logic [POS_W-1:0] FILLER_DELTA = 12'd255;

  localparam logic CMD_ENCODE = 1'b0;
  localparam logic CMD_DECODE = 1'b1;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENTRY   = 2'd0,
    KIND_FILLER  = 2'd1,
    KIND_RECORD  = 2'd2,
    KIND_DECODED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_RECORD,
    ST_DECODE
  } state_e;

endpackage

FILE: src/blocked_sparse_delta_codec_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blocked_sparse_delta_codec_core
// Blocked delta coordinate codec: encodes dense elements into delta entries
// with filler runs and block records, and decodes stored entries back into
// row and column inside the block.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+---------------------------------
//   in       | in_valid_i / in_ready_o  | command .. block_col_base
//   out      | out_valid_o / out_ready_i| kind .. last
//   cfg      | cfg_we_i                 | cfg_wdata_i (table_size)
//
// one word is accepted in idle, then the sequencer emits its results one per
// cycle: a kept element gives its fillers (up to 16), its entry and, if it
// closes a non-empty block, a block record; a decode gives one decoded word
// (none for a filler index), a skipped element only such a block record. the
// output register stalls the sequencer only while out_ready_i is low. reset
// clears all counters and table_size.
// ----------------------------------------------------------------------------
module blocked_sparse_delta_codec_core #(
  parameter int unsigned COL_SHIFT  = bsdc_pkg::COL_SHIFT_DEF,
  parameter int unsigned BLOCK_ROWS = bsdc_pkg::BLOCK_ROWS_DEF,
  parameter int unsigned ENTRY_BITS = bsdc_pkg::ENTRY_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,

  input  logic                         cfg_we_i,
  input  logic [bsdc_pkg::FIELD_W-1:0] cfg_wdata_i,

  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic                         first_of_block_i,
  input  logic                         last_of_block_i,
  input  logic [bsdc_pkg::FIELD_W-1:0] row_in_block_i,
  input  logic [bsdc_pkg::FIELD_W-1:0] col_in_block_i,
  input  logic [bsdc_pkg::FIELD_W-1:0] value_index_i,
  input  logic [bsdc_pkg::FIELD_W-1:0] pos_delta_i,
  input  logic [bsdc_pkg::BASE_W-1:0]  block_row_base_i,
  input  logic [bsdc_pkg::BASE_W-1:0]  block_col_base_i,

  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bsdc_pkg::KIND_W-1:0]  kind_o,
  output logic [bsdc_pkg::FIELD_W-1:0] out_delta_o,
  output logic [bsdc_pkg::FIELD_W-1:0] out_index_o,
  output logic [bsdc_pkg::RANGE_W-1:0] range_start_o,
  output logic [bsdc_pkg::RANGE_W-1:0] range_end_o,
  output logic [bsdc_pkg::FIELD_W-1:0] out_row_o,
  output logic [bsdc_pkg::FIELD_W-1:0] out_col_o,
  output logic                         last_o
);
  import bsdc_pkg::*;

  localparam logic [FIELD_W-1:0] COL_MASK = FIELD_W'((1 << COL_SHIFT) - 1);
  localparam logic [FIELD_W:0]   ROW_LIM  = (FIELD_W + 1)'(BLOCK_ROWS);

  state_e state_q, state_d;

  logic [FIELD_W-1:0]    table_size_q;
  logic [POS_W-1:0]      prev_pos_q, prev_pos_d;
  logic [ENTRY_BITS-1:0] entry_cnt_q, entry_cnt_d;
  logic [ENTRY_BITS-1:0] bfe_q, bfe_d;
  logic [POS_W-1:0]      dec_pos_q, dec_pos_d;
  logic [POS_W-1:0]      dist_q, dist_d;
  logic [FIELD_W-1:0]    idx_q, idx_d;
  logic                  close_q, close_d;

  logic                  out_valid_q;
  kind_e                 kind_q, kind_d;
  logic [FIELD_W-1:0]    delta_q, delta_d;
  logic [FIELD_W-1:0]    oidx_q, oidx_d;
  logic [RANGE_W-1:0]    rs_q, rs_d;
  logic [RANGE_W-1:0]    re_q, re_d;
  logic [FIELD_W-1:0]    orow_q, orow_d;
  logic [FIELD_W-1:0]    ocol_q, ocol_d;
  logic                  olast_q, olast_d;
  logic                  emit;

  logic                  accept;
  logic                  out_free;
  logic                  kept;
  logic [2*FIELD_W-1:0]  pos_wide;
  logic [POS_W-1:0]      pos_new;
  logic [POS_W-1:0]      prev_base;
  logic [POS_W-1:0]      dec_base;
  logic [POS_W-1:0]      dist_sub;
  logic                  dist_big;
  logic [ENTRY_BITS-1:0] cnt_plus;
  logic                  rec_after;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  assign kept = (table_size_q != '0) && (value_index_i < table_size_q)
             && ({1'b0, row_in_block_i} < ROW_LIM);
  assign pos_wide  = ({{FIELD_W{1'b0}}, row_in_block_i} << COL_SHIFT)
                   | {{FIELD_W{1'b0}}, col_in_block_i & COL_MASK};
  assign pos_new   = pos_wide[POS_W-1:0];
  assign prev_base = first_of_block_i ? '0 : prev_pos_q;
  assign dec_base  = first_of_block_i ? '0 : dec_pos_q;

  // shared delta unit
  assign dist_sub  = dist_q - FILLER_DELTA;
  assign dist_big  = dist_q > FILLER_DELTA;
  assign cnt_plus  = entry_cnt_q + ENTRY_BITS'(1);
  assign rec_after = close_q && (cnt_plus != bfe_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_DECODE) begin
            if (value_index_i != table_size_q) state_d = ST_DECODE;
          end else if (kept) begin
            state_d = ST_FILL;
          end else if (last_of_block_i && !first_of_block_i
                       && (entry_cnt_q != bfe_q)) begin
            state_d = ST_RECORD;
          end
        end
      end
      ST_FILL: begin
        if (out_free && !dist_big) state_d = rec_after ? ST_RECORD : ST_IDLE;
      end
      ST_RECORD: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_DECODE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and result words
  always_comb begin
    prev_pos_d  = prev_pos_q;
    entry_cnt_d = entry_cnt_q;
    bfe_d       = bfe_q;
    dec_pos_d   = dec_pos_q;
    dist_d      = dist_q;
    idx_d       = idx_q;
    close_d     = close_q;
    emit        = 1'b0;
    kind_d      = KIND_ENTRY;
    delta_d     = '0;
    oidx_d      = '0;
    rs_d        = '0;
    re_d        = '0;
    orow_d      = '0;
    ocol_d      = '0;
    olast_d     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          idx_d   = value_index_i;
          close_d = last_of_block_i;
          if (command_i == CMD_DECODE) begin
            dec_pos_d = dec_base + {{(POS_W-FIELD_W){1'b0}}, pos_delta_i};
          end else begin
            if (first_of_block_i) begin
              prev_pos_d = '0;
              bfe_d      = entry_cnt_q;
            end
            if (kept) begin
              dist_d     = pos_new - prev_base;
              prev_pos_d = pos_new;
            end
          end
        end
      end
      ST_FILL: begin
        if (out_free) begin
          emit        = 1'b1;
          entry_cnt_d = cnt_plus;
          if (dist_big) begin
            kind_d  = KIND_FILLER;
            delta_d = FILLER_DELTA[FIELD_W-1:0];
            oidx_d  = table_size_q;
            dist_d  = dist_sub;
          end else begin
            kind_d  = KIND_ENTRY;
            delta_d = dist_q[FIELD_W-1:0];
            oidx_d  = idx_q;
            olast_d = !rec_after;
          end
        end
      end
      ST_RECORD: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = KIND_RECORD;
          rs_d    = RANGE_W'(bfe_q);
          re_d    = RANGE_W'(entry_cnt_q);
          olast_d = 1'b1;
        end
      end
      ST_DECODE: begin
        if (out_free) begin
          emit    = 1'b1;
          kind_d  = KIND_DECODED;
          oidx_d  = idx_q;
          orow_d  = FIELD_W'(dec_pos_q >> COL_SHIFT);
          ocol_d  = dec_pos_q[FIELD_W-1:0] & COL_MASK;
          olast_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      table_size_q <= '0;
      prev_pos_q   <= '0;
      entry_cnt_q  <= '0;
      bfe_q        <= '0;
      dec_pos_q    <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      prev_pos_q  <= prev_pos_d;
      entry_cnt_q <= entry_cnt_d;
      bfe_q       <= bfe_d;
      dec_pos_q   <= dec_pos_d;
      if (cfg_we_i) table_size_q <= cfg_wdata_i;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q  <= dist_d;
    idx_q   <= idx_d;
    close_q <= close_d;
    if (emit) begin
      kind_q  <= kind_d;
      delta_q <= delta_d;
      oidx_q  <= oidx_d;
      rs_q    <= rs_d;
      re_q    <= re_d;
      orow_q  <= orow_d;
      ocol_q  <= ocol_d;
      olast_q <= olast_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign out_delta_o   = delta_q;
  assign out_index_o   = oidx_q;
  assign range_start_o = rs_q;
  assign range_end_o   = re_q;
  assign out_row_o     = orow_q;
  assign out_col_o     = ocol_q;
  assign last_o        = olast_q;

`ifndef SYNTHESIS
  a_record_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RECORD) |-> (entry_cnt_q != bfe_q))
    else $error("block record for an empty block");

  a_filler_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_FILLER)) |-> (!last_o && (out_delta_o == 8'd255)))
    else $error("malformed filler word");

  a_decoded_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (kind_o == KIND_DECODED || kind_o == KIND_RECORD)) |-> last_o)
    else $error("decoded or record word not marked last");

  a_fill_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FILL && out_free && dist_big) |=> (dist_q == $past(dist_sub)))
    else $error("filler run did not reduce the distance");
`endif

endmodule

FILE: tb/sv/blocked_sparse_delta_codec_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blocked_sparse_delta_codec_core_tb
// Self-checking bench for the blocked delta codec. It feeds encode blocks,
// decode runs and stray words with random gaps on both channels and a long
// output stall. A local model of the codec state predicts every result word,
// and each word is compared field by field in order.
// ----------------------------------------------------------------------------
module blocked_sparse_delta_codec_core_tb;

  import bsdc_pkg::*;

  localparam int unsigned COL_SHIFT    = COL_SHIFT_DEF;
  localparam int unsigned BLOCK_ROWS   = BLOCK_ROWS_DEF;
  localparam int unsigned ENTRY_BITS   = ENTRY_BITS_DEF;
  localparam int unsigned COL_MASK     = (1 << COL_SHIFT) - 1;
  localparam int          SETTLE_CYCLES = 40;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          CYCLE_LIMIT   = 400000;
  localparam int          PRINT_LIMIT   = 200;

  typedef struct packed {
    logic                cmd;
    logic                first;
    logic                last;
    logic [FIELD_W-1:0]  row;
    logic [FIELD_W-1:0]  col;
    logic [FIELD_W-1:0]  vidx;
    logic [FIELD_W-1:0]  pdelta;
    logic [BASE_W-1:0]   row_base;
    logic [BASE_W-1:0]   col_base;
  } codec_word_t;

  typedef struct packed {
    kind_e               kind;
    logic [FIELD_W-1:0]  delta;
    logic [FIELD_W-1:0]  index;
    logic [RANGE_W-1:0]  rstart;
    logic [RANGE_W-1:0]  rend;
    logic [FIELD_W-1:0]  row;
    logic [FIELD_W-1:0]  col;
    logic                last;
  } codec_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we = 1'b0;
  logic [FIELD_W-1:0]   cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  codec_word_t          in_word = '0;
  logic                 out_valid;
  logic                 out_ready;
  logic                 rx_open = 1'b0;
  logic                 rx_hold = 1'b0;
  logic [KIND_W-1:0]    kind;
  logic [FIELD_W-1:0]   out_delta;
  logic [FIELD_W-1:0]   out_index;
  logic [RANGE_W-1:0]   range_start;
  logic [RANGE_W-1:0]   range_end;
  logic [FIELD_W-1:0]   out_row;
  logic [FIELD_W-1:0]   out_col;
  logic                 out_last;

  // model state
  logic [FIELD_W-1:0]    table_size_m = '0;
  logic [POS_W-1:0]      prev_pos_m = '0;
  logic [ENTRY_BITS-1:0] entry_count_m = '0;
  logic [ENTRY_BITS-1:0] block_first_m = '0;
  logic [POS_W-1:0]      decode_pos_m = '0;

  codec_word_t   pending_words[$];
  codec_result_t awaited_results[$];

  int  words_queued = 0;
  int  words_taken = 0;
  int  results_seen = 0;
  int  mismatch_count = 0;
  int  cycle_count = 0;
  int  tx_gap = 0;
  int  rx_wait = 0;
  bit  tx_steady = 1'b0;
  bit  rx_steady = 1'b0;
  bit  in_accepted = 1'b0;
  bit  out_accepted = 1'b0;
  bit  hold_go = 1'b0;

  assign out_ready = rx_open && !rx_hold;

  blocked_sparse_delta_codec_core dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .command_i        (in_word.cmd),
    .first_of_block_i (in_word.first),
    .last_of_block_i  (in_word.last),
    .row_in_block_i   (in_word.row),
    .col_in_block_i   (in_word.col),
    .value_index_i    (in_word.vidx),
    .pos_delta_i      (in_word.pdelta),
    .block_row_base_i (in_word.row_base),
    .block_col_base_i (in_word.col_base),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .kind_o           (kind),
    .out_delta_o      (out_delta),
    .out_index_o      (out_index),
    .range_start_o    (range_start),
    .range_end_o      (range_end),
    .out_row_o        (out_row),
    .out_col_o        (out_col),
    .last_o           (out_last)
  );

  always #10 clk_i = ~clk_i;

  function automatic void push_result(kind_e k, logic [FIELD_W-1:0] d,
                                      logic [FIELD_W-1:0] ix,
                                      logic [RANGE_W-1:0] rs,
                                      logic [RANGE_W-1:0] re,
                                      logic [FIELD_W-1:0] r,
                                      logic [FIELD_W-1:0] c);
    codec_result_t e;
    e.kind   = k;
    e.delta  = d;
    e.index  = ix;
    e.rstart = rs;
    e.rend   = re;
    e.row    = r;
    e.col    = c;
    e.last   = 1'b0;
    awaited_results.insert(awaited_results.size(), e);
  endfunction

  function automatic void derive_codec_results(codec_word_t w);
    int               before_n;
    int unsigned      p;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] gap;
    before_n = awaited_results.size();
    if (w.cmd == CMD_DECODE) begin
      if (w.first) begin
        decode_pos_m = '0;
      end
      decode_pos_m = decode_pos_m + POS_W'(w.pdelta);
      if (w.vidx != table_size_m) begin
        push_result(KIND_DECODED, '0, w.vidx, '0, '0,
                    FIELD_W'(decode_pos_m >> COL_SHIFT),
                    FIELD_W'(decode_pos_m & COL_MASK));
      end
    end else begin
      if (w.first) begin
        prev_pos_m    = '0;
        block_first_m = entry_count_m;
      end
      if (table_size_m != 0 && w.vidx < table_size_m && w.row < BLOCK_ROWS) begin
        p   = (int'(w.row) << COL_SHIFT) | (int'(w.col) & COL_MASK);
        pos = POS_W'(p);
        gap = pos - prev_pos_m;
        while (gap > FILLER_DELTA) begin
          push_result(KIND_FILLER, FIELD_W'(FILLER_DELTA), table_size_m, '0, '0,
                      '0, '0);
          entry_count_m = entry_count_m + 1'b1;
          gap = gap - FILLER_DELTA;
        end
        push_result(KIND_ENTRY, FIELD_W'(gap), w.vidx, '0, '0, '0, '0);
        entry_count_m = entry_count_m + 1'b1;
        prev_pos_m = pos;
      end
      if (w.last && entry_count_m != block_first_m) begin
        push_result(KIND_RECORD, '0, '0, RANGE_W'(block_first_m),
                    RANGE_W'(entry_count_m), '0, '0);
      end
    end
    if (awaited_results.size() > before_n) begin
      awaited_results[awaited_results.size()-1].last = 1'b1;
    end
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("result word %0d: %s got %0h want %0h", results_seen, field, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_result(codec_result_t want);
    if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
    if (out_delta !== want.delta) report_mismatch("out_delta", out_delta, want.delta);
    if (out_index !== want.index) report_mismatch("out_index", out_index, want.index);
    if (range_start !== want.rstart) report_mismatch("range_start", range_start, want.rstart);
    if (range_end !== want.rend) report_mismatch("range_end", range_end, want.rend);
    if (out_row !== want.row) report_mismatch("out_row", out_row, want.row);
    if (out_col !== want.col) report_mismatch("out_col", out_col, want.col);
    if (out_last !== want.last) report_mismatch("last", out_last, want.last);
  endtask

  // accept side: prediction on input words, comparison on output words
  always @(posedge clk_i) begin : monitor
    if (rst_ni) begin
      cycle_count++;
      if (in_valid && in_ready) begin
        derive_codec_results(in_word);
        words_taken++;
        in_accepted = 1'b1;
      end
      if (out_valid && out_ready) begin
        out_accepted = 1'b1;
        if (awaited_results.size() == 0) begin
          report_mismatch("unexpected word kind", kind, '1);
        end else begin
          check_result(awaited_results.pop_front());
        end
        results_seen++;
      end
    end
  end

  always @(negedge clk_i) begin : word_driver
    logic keep;
    if (rst_ni) begin
      keep = in_valid && !in_accepted;
      in_accepted = 1'b0;
      if (!keep) begin
        if (tx_gap != 0) begin
          tx_gap--;
        end else if (pending_words.size() != 0) begin
          in_word <= pending_words.pop_front();
          keep = 1'b1;
          tx_gap = tx_steady ? 0 : $urandom_range(0, 4);
          if ($urandom_range(0, 31) == 0) tx_steady = !tx_steady;
        end
      end
      in_valid <= keep;
    end
  end

  always @(negedge clk_i) begin : result_sink
    if (rst_ni) begin
      if (out_accepted) begin
        out_accepted = 1'b0;
        rx_wait = rx_steady ? 0 : $urandom_range(0, 4);
        if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      end
      if (rx_wait != 0) begin
        rx_wait--;
        rx_open <= 1'b0;
      end else begin
        rx_open <= 1'b1;
      end
    end
  end

  // long output stall while the sender keeps offering words
  initial begin
    wait (hold_go);
    @(negedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("blocked_sparse_delta_codec_core: mismatch");
    $finish;
  end

  function automatic codec_word_t rand_word();
    codec_word_t w;
    w.cmd      = 1'($urandom);
    w.first    = 1'($urandom);
    w.last     = 1'($urandom);
    w.row      = FIELD_W'($urandom);
    w.col      = FIELD_W'($urandom);
    w.vidx     = FIELD_W'($urandom);
    w.pdelta   = FIELD_W'($urandom);
    w.row_base = BASE_W'($urandom);
    w.col_base = BASE_W'($urandom);
    return w;
  endfunction

  function automatic codec_word_t enc_word(logic first, logic last, logic [7:0] row,
                                           logic [7:0] col, logic [7:0] vidx);
    codec_word_t w;
    w       = rand_word();
    w.cmd   = CMD_ENCODE;
    w.first = first;
    w.last  = last;
    w.row   = row;
    w.col   = col;
    w.vidx  = vidx;
    return w;
  endfunction

  function automatic codec_word_t dec_word(logic first, logic [7:0] pdelta,
                                           logic [7:0] vidx);
    codec_word_t w;
    w        = rand_word();
    w.cmd    = CMD_DECODE;
    w.first  = first;
    w.pdelta = pdelta;
    w.vidx   = vidx;
    return w;
  endfunction

  task automatic add_word(codec_word_t w);
    pending_words.insert(pending_words.size(), w);
    words_queued++;
  endtask

  // raster-ordered block with occasional long jumps
  task automatic add_block(int len, logic [7:0] ts);
    int unsigned pos;
    int          k;
    logic [7:0]  vidx;
    pos = $urandom_range(0, 64);
    for (k = 0; k < len; k++) begin
      if (k > 0) begin
        pos += ($urandom_range(0, 5) == 0) ? $urandom_range(200, 800)
                                           : $urandom_range(1, 40);
      end
      if (pos > 4095) pos = $urandom_range(0, 4095);
      if (ts != 0 && $urandom_range(0, 4) != 0) vidx = 8'($urandom_range(0, ts - 1));
      else vidx = 8'($urandom);
      add_word(enc_word(k == 0, k == len - 1, 8'(pos >> COL_SHIFT),
                        8'(($urandom() << COL_SHIFT) | (pos & COL_MASK)), vidx));
    end
  endtask

  task automatic add_decode_run(logic [7:0] ts);
    int         len;
    int         k;
    bit         longrun;
    bit         opens;
    logic [7:0] vidx;
    longrun = ($urandom_range(0, 4) == 0);
    len     = longrun ? $urandom_range(8, 20) : $urandom_range(1, 6);
    opens   = ($urandom_range(0, 3) != 0);
    for (k = 0; k < len; k++) begin
      vidx = ($urandom_range(0, 4) == 0) ? ts : 8'($urandom);
      add_word(dec_word(opens && k == 0,
                        longrun ? 8'($urandom_range(128, 255)) : 8'($urandom), vidx));
    end
  endtask

  task automatic queue_random(int n, logic [7:0] ts);
    int target;
    int sel;
    target = words_queued + n;
    while (words_queued < target) begin
      sel = $urandom_range(0, 19);
      if (sel < 13) add_block($urandom_range(1, 6), ts);
      else if (sel < 17) add_decode_run(ts);
      else add_word(rand_word());
    end
  endtask

  task automatic wait_idle();
    while (words_taken != words_queued || awaited_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_table_size(logic [7:0] v);
    wait_idle();
    cfg_wdata <= v;
    cfg_we    <= 1'b1;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
    table_size_m = v;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // table size zero out of reset: encode silent, decode still live
    add_word(enc_word(1'b1, 1'b0, 8'd2, 8'd3, 8'd0));
    add_word(dec_word(1'b1, 8'd5, 8'd0));
    add_word(dec_word(1'b0, 8'd3, 8'd9));
    add_word(enc_word(1'b0, 1'b1, 8'd4, 8'd4, 8'd1));

    write_table_size(8'd200);
    // longest burst: 16 fillers, entry and record
    add_word(enc_word(1'b1, 1'b0, 8'd0, 8'd0, 8'd0));
    add_word(enc_word(1'b0, 1'b1, 8'd255, 8'd255, 8'd199));
    // backward step wraps around
    add_word(enc_word(1'b1, 1'b0, 8'd6, 8'd4, 8'd5));
    add_word(enc_word(1'b0, 1'b0, 8'd3, 8'd2, 8'd6));
    // distance exactly 255, then 256
    add_word(enc_word(1'b0, 1'b0, 8'd19, 8'd1, 8'd7));
    add_word(enc_word(1'b0, 1'b1, 8'd35, 8'd1, 8'd8));
    // empty blocks, then a one-element block at position zero
    add_word(enc_word(1'b1, 1'b1, 8'd1, 8'd1, 8'd200));
    add_word(enc_word(1'b1, 1'b1, 8'd1, 8'd1, 8'd255));
    add_word(enc_word(1'b1, 1'b1, 8'd0, 8'd0, 8'd0));
    // record on a skipped closing element
    add_word(enc_word(1'b1, 1'b0, 8'd1, 8'd1, 8'd0));
    add_word(enc_word(1'b0, 1'b0, 8'd2, 8'd2, 8'd250));
    add_word(enc_word(1'b0, 1'b1, 8'd3, 8'd3, 8'd201));
    // decode: plain, filler, index above table size, reopen
    add_word(dec_word(1'b1, 8'd0, 8'd0));
    add_word(dec_word(1'b0, 8'd255, 8'd200));
    add_word(dec_word(1'b0, 8'd255, 8'd255));
    add_word(dec_word(1'b0, 8'd255, 8'd199));
    add_word(dec_word(1'b1, 8'd255, 8'd1));

    write_table_size(8'd255);
    queue_random(60, 8'd255);
    hold_go = 1'b1;

    write_table_size(8'd1);
    queue_random(40, 8'd1);

    write_table_size(8'd0);
    queue_random(20, 8'd0);

    write_table_size(8'($urandom_range(2, 254)));
    queue_random(60, table_size_m);

    write_table_size(8'($urandom_range(2, 254)));
    queue_random(60, table_size_m);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("blocked_sparse_delta_codec_core: match");
    end else begin
      $display("blocked_sparse_delta_codec_core: mismatch");
    end
    $finish;
  end

endmodule
